/* hw/rtl/vsm_pkg.sv */
`default_nettype none
package vsm_pkg;
    localparam int COORD_W = 32;
    localparam int DELTA_W = 33;
    localparam int STEP_W  = 17;
    localparam int CELL_W  = 16;
    localparam int SQ_W    = 64;
    localparam int ROOT_W  = 33;
    localparam int POS_W   = 40;
    localparam int INC_W   = 34;
    localparam logic [STEP_W-1:0] STEP_RESET = 17'd6554;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx, sy, sz;
        logic signed [DELTA_W-1:0] dx, dy, dz;
        logic [SQ_W-1:0]           sq;
        logic                      big;
    } t_job;

    typedef struct packed {
        logic [CELL_W-1:0] cx, cy, cz;
        logic              last;
        logic              trunc;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE, ST_COUNT, ST_START, ST_SQ2, ST_ROOT, ST_DIV, ST_MARCH, ST_EMIT, ST_FLUSH
    } t_state;
endpackage
`default_nettype wire

/* hw/rtl/vsm_front.sv */
`default_nettype none
module vsm_front
    import vsm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [6*COORD_W-1:0]  i_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_job                       o_job
);
    // classifier pipeline: registered deltas, then registered saturated sum of squares
    logic                      r_v1, r_v2;
    logic signed [COORD_W-1:0] r_s [3];
    logic signed [DELTA_W-1:0] r_d [3];
    logic signed [COORD_W-1:0] r_s2 [3];
    logic signed [DELTA_W-1:0] r_d2 [3];
    logic [SQ_W-1:0]           r_sq;
    logic                      r_big;
    logic [DELTA_W-1:0]        w_m [3];
    logic [SQ_W+1:0]           w_sum;
    logic                      w_adv;

    always_comb begin
        for (int i = 0; i < 3; i++)
            w_m[i] = r_d[i][DELTA_W-1] ? DELTA_W'(-r_d[i]) : DELTA_W'(r_d[i]);
        w_sum = (SQ_W+2)'(w_m[0] * w_m[0]) + (SQ_W+2)'(w_m[1] * w_m[1])
              + (SQ_W+2)'(w_m[2] * w_m[2]);
    end

    assign w_adv   = !r_v2 || i_ready;
    assign o_ready = !r_v1 || w_adv;
    assign o_valid = r_v2;
    assign o_job   = '{sx: r_s2[0], sy: r_s2[1], sz: r_s2[2], dx: r_d2[0], dy: r_d2[1],
                       dz: r_d2[2], sq: r_sq, big: r_big};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv) r_v2 <= r_v1;
            if (o_ready) r_v1 <= i_valid;
        end
        if (w_adv && r_v1) begin
            r_sq  <= (w_sum[SQ_W+1:SQ_W] != 2'd0) ? {SQ_W{1'b1}} : w_sum[SQ_W-1:0];
            r_big <= (w_m[0] > 33'h7FFFFFFF) || (w_m[1] > 33'h7FFFFFFF)
                  || (w_m[2] > 33'h7FFFFFFF);
            for (int i = 0; i < 3; i++) begin
                r_s2[i] <= r_s[i];
                r_d2[i] <= r_d[i];
            end
        end
        if (o_ready && i_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_s[i] <= i_data[i*COORD_W +: COORD_W];
                r_d[i] <= DELTA_W'($signed(i_data[(i+3)*COORD_W +: COORD_W]))
                        - DELTA_W'($signed(i_data[i*COORD_W +: COORD_W]));
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/vsm_fifo.sv */
`default_nettype none
module vsm_fifo
    import vsm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_job      i_job,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_job      o_job
);
    // two-entry job queue
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];
    assign w_wr    = i_valid && o_ready;
    assign w_rd    = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
        if (w_wr) r_mem[r_wp] <= i_job;
    end
endmodule
`default_nettype wire

/* hw/rtl/vsm_back.sv */
`default_nettype none
module vsm_back
    import vsm_pkg::*;
#(
    parameter int MAX_STEPS = 63,
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [STEP_W-1:0] i_step,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  t_job                   i_job,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_res                   o_res
);
    localparam int NW = $clog2(MAX_STEPS + 2);
    localparam int QW = 52;

    t_state r_st, n_st;
    logic [NW-1:0]        r_k, r_n;
    logic [STEP_W-1:0]    r_s;
    logic [STEP_W+NW-1:0] r_t;
    logic [SQ_W-1:0]      r_sq, r_x;
    logic [ROOT_W-1:0]    r_len;
    logic [5:0]           r_it;
    logic [1:0]           r_ax;
    logic [QW-1:0]        r_num, r_q;
    logic [ROOT_W:0]      r_rem;
    logic signed [DELTA_W-1:0] r_d [3];
    logic signed [INC_W-1:0]   r_inc [3];
    logic signed [POS_W-1:0]   r_pos [3];
    logic [CELL_W-1:0]    r_last [3];
    logic                 r_trunc, r_ov;
    t_res                 r_res;
    t_res                 r_pend;
    logic [CELL_W-1:0]    w_cur [3];
    logic [DELTA_W-1:0]   w_mag;
    logic [2*(STEP_W+NW)-1:0] w_tt;
    logic [ROOT_W:0]      w_rs;
    logic signed [INC_W-1:0]  w_inc2;
    logic                 w_out_free, w_chg;

    assign w_out_free = !r_ov || i_ready;
    assign o_valid = r_ov;
    assign o_res   = r_res;
    assign o_ready = r_st == ST_IDLE;
    assign w_tt    = r_t * r_t;
    assign w_mag   = r_d[r_ax][DELTA_W-1] ? DELTA_W'(-r_d[r_ax]) : DELTA_W'(r_d[r_ax]);
    assign w_inc2  = r_d[2][DELTA_W-1] ? -INC_W'(r_q) : INC_W'(r_q);
    // restoring root step, two bits per cycle
    assign w_rs    = {r_rem[ROOT_W-2:0], r_x[SQ_W-1:SQ_W-2]} - {r_len[ROOT_W-2:0], 2'b01};
    always_comb begin
        for (int i = 0; i < 3; i++) w_cur[i] = r_pos[i][FRAC_BITS +: CELL_W];
        w_chg = (w_cur[0] != r_last[0]) || (w_cur[1] != r_last[1])
             || (w_cur[2] != r_last[2]);
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (i_valid) n_st = ST_COUNT;
            ST_COUNT: if (r_k == NW'(MAX_STEPS + 1) || w_tt > (2*(STEP_W+NW))'(r_sq)
                          && r_sq < SQ_W'(1) << (2*(STEP_W+NW)) || w_tt > r_sq)
                          n_st = ST_START;
            ST_START: n_st = (r_n == '0) ? ST_FLUSH : ST_SQ2;
            ST_SQ2:   n_st = (r_ax == 2'd2) ? ST_ROOT : ST_SQ2;
            ST_ROOT:  if (r_it == 6'd31) n_st = ST_DIV;
            ST_DIV:   if (r_it == 6'(QW) && r_ax == 2'd2) n_st = ST_MARCH;
            ST_MARCH: n_st = ST_EMIT;
            ST_EMIT:  if (w_out_free || !w_chg) n_st = (r_k == r_n) ? ST_FLUSH : ST_MARCH;
            ST_FLUSH: if (w_out_free) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if ((r_st == ST_EMIT && w_out_free && w_chg) || (r_st == ST_FLUSH && w_out_free))
                r_ov <= 1'b1;
            else if (i_ready)
                r_ov <= 1'b0;
        end
        unique case (r_st)
            ST_IDLE: begin
                r_s  <= (i_step == '0) ? STEP_W'(1) : i_step;
                r_t  <= (STEP_W+NW)'((i_step == '0) ? STEP_W'(1) : i_step);
                r_k  <= NW'(1);
                r_n  <= '0;
                r_sq <= i_job.sq;
                r_d[0] <= i_job.big ? $signed(i_job.dx) >>> 1 : $signed(i_job.dx);
                r_d[1] <= i_job.big ? $signed(i_job.dy) >>> 1 : $signed(i_job.dy);
                r_d[2] <= i_job.big ? $signed(i_job.dz) >>> 1 : $signed(i_job.dz);
                r_pos[0] <= POS_W'($signed(i_job.sx));
                r_pos[1] <= POS_W'($signed(i_job.sy));
                r_pos[2] <= POS_W'($signed(i_job.sz));
            end
            ST_COUNT: begin
                // largest k with (k*s)^2 <= S, one k per cycle
                if (w_tt <= (2*(STEP_W+NW))'(r_sq) || r_sq >= SQ_W'(1) << (2*(STEP_W+NW)))
                    if (r_k != NW'(MAX_STEPS + 1)) r_n <= r_k;
                if (r_k == NW'(MAX_STEPS + 1)) begin
                    r_trunc <= (w_tt <= (2*(STEP_W+NW))'(r_sq)
                                || r_sq >= SQ_W'(1) << (2*(STEP_W+NW)));
                end else begin
                    r_trunc <= 1'b0;
                end
                r_k <= r_k + NW'(1);
                r_t <= r_t + (STEP_W+NW)'(r_s);
                r_x <= '0;
                r_ax <= 2'd0;
            end
            ST_START: begin
                // hold the start cell until it is known whether it is the last
                for (int i = 0; i < 3; i++) r_last[i] <= w_cur[i];
                r_pend <= '{cx: w_cur[0], cy: w_cur[1], cz: w_cur[2],
                            last: 1'b0, trunc: r_trunc};
                if (r_trunc) r_n <= NW'(MAX_STEPS);
                r_k <= '0;
            end
            ST_SQ2: begin
                r_x  <= r_x + SQ_W'(w_mag * w_mag);
                r_ax <= r_ax + 2'd1;
                r_it <= '0;
                r_rem <= '0;
                r_len <= '0;
            end
            ST_ROOT: begin
                if (!w_rs[ROOT_W]) begin
                    r_rem <= w_rs;
                    r_len <= {r_len[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[ROOT_W-2:0], r_x[SQ_W-1:SQ_W-2]};
                    r_len <= {r_len[ROOT_W-2:0], 1'b0};
                end
                r_x  <= {r_x[SQ_W-3:0], 2'b00};
                if (r_it == 6'd31) begin
                    r_ax <= 2'd0;
                    r_it <= '0;
                end else begin
                    r_it <= r_it + 6'd1;
                end
            end
            ST_DIV: begin
                // restoring divide, one quotient bit per cycle, axis by axis
                if (r_it == '0) begin
                    if (r_len == '0) r_len <= ROOT_W'(1);
                    r_num <= QW'(w_mag) * QW'(r_s)
                           + QW'(((r_len == '0) ? ROOT_W'(1) : r_len) >> 1);
                    r_rem <= '0;
                    r_q   <= '0;
                    r_it  <= 6'd1;
                end else begin
                    r_num <= {r_num[QW-2:0], 1'b0};
                    if ({r_rem[ROOT_W-1:0], r_num[QW-1]} >= {1'b0, r_len}) begin
                        r_rem <= {r_rem[ROOT_W-1:0], r_num[QW-1]} - {1'b0, r_len};
                        r_q   <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[ROOT_W-1:0], r_num[QW-1]};
                        r_q   <= {r_q[QW-2:0], 1'b0};
                    end
                    if (r_it == 6'(QW)) begin
                        r_it <= '0;
                        r_ax <= r_ax + 2'd1;
                    end else begin
                        r_it <= r_it + 6'd1;
                    end
                end
                if (r_it == '0 && r_ax != 2'd0) begin
                    r_inc[r_ax - 2'd1] <= r_d[r_ax - 2'd1][DELTA_W-1]
                        ? -INC_W'(r_q) : INC_W'(r_q);
                end
            end
            ST_MARCH: begin
                if (r_ax == 2'd3) r_inc[2] <= w_inc2;
                for (int i = 0; i < 3; i++)
                    r_pos[i] <= r_pos[i] + POS_W'((r_ax == 2'd3 && i == 2)
                        ? w_inc2 : r_inc[i]);
                r_ax <= 2'd0;
                r_k  <= r_k + NW'(1);
            end
            ST_EMIT: if (w_chg && w_out_free) begin
                // release the held cell, hold the new one
                for (int i = 0; i < 3; i++) r_last[i] <= w_cur[i];
                r_res  <= r_pend;
                r_pend <= '{cx: w_cur[0], cy: w_cur[1], cz: w_cur[2],
                            last: 1'b0, trunc: r_trunc};
            end
            ST_FLUSH: if (w_out_free) begin
                // release the held cell as the last of the run
                r_res <= '{cx: r_pend.cx, cy: r_pend.cy, cz: r_pend.cz,
                           last: 1'b1, trunc: r_pend.trunc};
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

/* hw/rtl/voxel_segment_march.sv */
`default_nettype none
// Voxel segment march. A segment (start and end, signed fixed point) enters on the
// slave beat; the cells it crosses leave one per master beat, tlast on the final
// one. The back end takes one segment at a time: it accepts it, searches for the
// step count, starts, sums the squares, takes a two-bit-per-cycle square root,
// runs a one-bit-per-cycle divide per axis, marches, and releases the last cell;
// output stalls hold the march. A segment shorter than one step skips from the start
// to the release of the last cell. The front end and a two-entry queue take the
// next segment meanwhile.
module voxel_segment_march
    import vsm_pkg::*;
#(
    parameter int MAX_STEPS = 63,
    parameter int FRAC_BITS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [16:0]  i_cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  wire logic [191:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // cell_x, cell_y, cell_z
    output logic [47:0]       m_axis_tdata,
    output logic              m_axis_tlast,
    // truncated
    output logic              m_axis_tuser
);
    logic [STEP_W-1:0] r_step;
    logic fv, fr, qv, qr;
    t_job fj, qj;
    t_res res;

    // hold step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_step <= STEP_RESET;
        else if (i_cfg_we) r_step <= i_cfg_wdata;
    end

    vsm_front u_front (.i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata), .o_valid(fv), .i_ready(fr), .o_job(fj));
    vsm_fifo u_fifo (.i_clk, .i_rst_n, .i_valid(fv), .o_ready(fr), .i_job(fj),
        .o_valid(qv), .i_ready(qr), .o_job(qj));
    vsm_back #(.MAX_STEPS(MAX_STEPS), .FRAC_BITS(FRAC_BITS)) u_back (.i_clk, .i_rst_n,
        .i_step(r_step), .i_valid(qv), .o_ready(qr), .i_job(qj),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res));

    assign m_axis_tdata = {res.cz, res.cy, res.cx};
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = res.trunc;
endmodule
`default_nettype wire

/* hw/rtl/vsm_check.sv */
`default_nettype none
module vsm_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("beat dropped");
    // non-last beats within a run differ from the previous beat
    a_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
        |-> m_axis_tdata != $past(m_axis_tdata) || m_axis_tlast)
        else $error("repeated cell");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule
bind voxel_segment_march vsm_check u_check (.i_clk, .i_rst_n, .m_axis_tvalid,
    .m_axis_tready, .m_axis_tdata, .m_axis_tlast);
`default_nettype wire

/* tb/tb_voxel_segment_march.sv */
`default_nettype none
module tb_voxel_segment_march;
    import vsm_pkg::*;

    localparam int MAX_STEPS = 63;
    localparam int FRAC_BITS = 16;
    localparam int DRAIN_CYCLES = 700;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 1500;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [16:0]  i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // start_x, start_y, start_z, end_x, end_y, end_z
    logic [191:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // cell_x, cell_y, cell_z
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tlast;
    // truncated
    logic         m_axis_tuser;

    voxel_segment_march #(.MAX_STEPS(MAX_STEPS), .FRAC_BITS(FRAC_BITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    bit [191:0] segs_pending[$];
    t_res       cells_due[$];
    bit [16:0]  step_now;
    int         src_idle_pct;
    int         snk_stall_pct;
    int         errors;
    longint     cycles;
    bit         hold_req;
    bit         hold_ack;
    int         hold_cnt;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit [63:0] mag64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic bit [63:0] root64(input bit [63:0] x);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Work out the cells a segment visits and queue them as expected beats.
    function automatic void march_segment(input bit [191:0] seg);
        longint    pos[3];
        longint    d[3];
        longint    inc[3];
        bit [63:0] s, sq, sq2, m, sum, t, len, q;
        bit [15:0] cur[3];
        bit [15:0] prev[3];
        int        n;
        bit        trunc, big, moved;
        t_res      run[$];
        t_res      r;
        s = (step_now == 0) ? 64'd1 : 64'(step_now);
        sq = 0;
        big = 0;
        for (int i = 0; i < 3; i++) begin
            pos[i] = longint'($signed(seg[32*i +: 32]));
            d[i] = longint'($signed(seg[32*(i+3) +: 32])) - pos[i];
            m = mag64(d[i]);
            sum = sq + m * m;
            sq = (sum < sq) ? 64'hFFFF_FFFF_FFFF_FFFF : sum;
            if (m > 64'h7FFF_FFFF) big = 1;
        end
        n = 0;
        for (int k = 1; k <= MAX_STEPS + 1; k++) begin
            t = 64'(k) * s;
            if (t * t <= sq) n = k;
        end
        trunc = (n > MAX_STEPS);
        if (trunc) n = MAX_STEPS;
        for (int i = 0; i < 3; i++) prev[i] = 16'(pos[i] >>> FRAC_BITS);
        r.cx = prev[0]; r.cy = prev[1]; r.cz = prev[2];
        r.last = 0; r.trunc = trunc;
        run.push_back(r);
        if (n > 0) begin
            sq2 = 0;
            for (int i = 0; i < 3; i++) begin
                if (big) d[i] = d[i] >>> 1;
                sq2 += mag64(d[i]) * mag64(d[i]);
            end
            len = root64(sq2);
            if (len == 0) len = 1;
            for (int i = 0; i < 3; i++) begin
                q = (mag64(d[i]) * s + len / 2) / len;
                inc[i] = d[i] < 0 ? -longint'(q) : longint'(q);
            end
            for (int k = 0; k < n; k++) begin
                moved = 0;
                for (int i = 0; i < 3; i++) begin
                    pos[i] += inc[i];
                    cur[i] = 16'(pos[i] >>> FRAC_BITS);
                    if (cur[i] != prev[i]) moved = 1;
                end
                if (moved) begin
                    r.cx = cur[0]; r.cy = cur[1]; r.cz = cur[2];
                    run.push_back(r);
                    prev = cur;
                end
            end
        end
        run[run.size()-1].last = 1;
        foreach (run[j]) cells_due.push_back(run[j]);
    endfunction

    // Drive segment beats; predict on each accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) march_segment(s_axis_tdata);
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (segs_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_axis_tdata <= segs_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Stall the result side at random, or hold it off for a long stretch on request.
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_cnt <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Check each result beat against the oldest expected cell.
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cells_due.size() == 0) begin
                $display("%0t: unexpected cell beat data=%h last=%b trunc=%b", $time,
                    m_axis_tdata, m_axis_tlast, m_axis_tuser);
                errors++;
            end else begin
                e = cells_due.pop_front();
                if (m_axis_tdata !== {e.cz, e.cy, e.cx} || m_axis_tlast !== e.last
                        || m_axis_tuser !== e.trunc) begin
                    $display("%0t: cell mismatch expected xyz=%h last=%b trunc=%b", $time,
                        {e.cz, e.cy, e.cx}, e.last, e.trunc);
                    $display("%0t:               actual   xyz=%h last=%b trunc=%b", $time,
                        m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_step(input bit [16:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        step_now = v;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (segs_pending.size() > 0 || s_axis_tvalid || cells_due.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic bit [191:0] seg_of(input int sx, sy, sz, ex, ey, ez);
        return {ez, ey, ex, sz, sy, sx};
    endfunction

    // Mostly short segments near a random point, some fully random, some degenerate.
    function automatic bit [191:0] rand_seg();
        int s3[3];
        int e3[3];
        int kind;
        kind = $urandom_range(99);
        for (int i = 0; i < 3; i++) begin
            s3[i] = (kind < 30) ? $urandom() : $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
            if (kind < 12)
                e3[i] = $urandom();
            else if (kind < 17)
                e3[i] = s3[i];
            else
                e3[i] = s3[i] + ($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
        end
        return seg_of(s3[0], s3[1], s3[2], e3[0], e3[1], e3[2]);
    endfunction

    task automatic run_phase(input bit [16:0] st, input int src, input int snk, input int cnt);
        write_step(st);
        src_idle_pct = src;
        snk_stall_pct = snk;
        repeat (cnt) segs_pending.push_back(rand_seg());
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        step_now = STEP_RESET;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        errors = 0;
        cycles = 0;
        hold_req = 0;
        hold_ack = 0;
        hold_cnt = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset step size
        segs_pending.push_back(seg_of(0, 0, 0, 0, 0, 0));                       // zero length
        segs_pending.push_back(seg_of(0, 0, 0, 65536, 0, 0));                   // one unit along x
        segs_pending.push_back(seg_of(-1, -1, -1, -65537, 98304, 32768));       // negative floors
        segs_pending.push_back(seg_of(0, 0, 0, 6554 * 5, 0, 0));                // exact step multiple
        segs_pending.push_back(seg_of(0, 0, 0, 6554 * 5 - 1, 0, 0));
        segs_pending.push_back(seg_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));                      // extreme deltas
        segs_pending.push_back(seg_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        segs_pending.push_back(seg_of(32'h7FFF_0000, 0, 32'h8000_0000,
            32'h8003_0000, 0, 32'h7FFF_0000));                                  // cell wrap
        segs_pending.push_back(seg_of(32'h0FFF_8000, -32'sh1000_0000, 0,
            32'h1000_8000, -32'sh0FFF_0000, 0));                                // beyond 16 bits
        segs_pending.push_back(seg_of(0, 0, 0, 0, 0, 20 * 65536));              // truncated
        segs_pending.push_back(seg_of(100, 200, 300, 100, 200, 300 + 6553));    // just under a step
        segs_pending.push_back(seg_of(65535, 65535, 65535, 0, 0, 0));
        wait_drained();

        // directed: extreme step sizes; pause until all cells are out
        write_step(17'd65536);
        segs_pending.push_back(seg_of(0, 0, 0, 65536, 65536, 65536));
        segs_pending.push_back(seg_of(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0));
        segs_pending.push_back(seg_of(0, 0, 0, 65535, 0, 0));
        wait_drained();
        write_step(17'd1);
        segs_pending.push_back(seg_of(0, 0, 0, 63, 0, 0));
        segs_pending.push_back(seg_of(0, 0, 0, 64, 0, 0));
        segs_pending.push_back(seg_of(-30000, 5, 7, 30000, -5, -7));
        wait_drained();
        write_step(17'd0);                                                      // acts as one
        segs_pending.push_back(seg_of(0, 0, 0, 63, 0, 0));
        segs_pending.push_back(seg_of(-65536, 0, 0, 65536, 0, 0));
        wait_drained();

        // random phases across step sizes and idling patterns
        run_phase(17'd6554, 0, 0, 30);
        run_phase(17'd65536, 74, 0, 30);
        run_phase(17'd1, 0, 74, 30);
        run_phase(17'($urandom_range(1, 65536)), 24, 24, 30);
        run_phase(17'd0, 24, 24, 20);
        run_phase(17'($urandom_range(1000, 20000)), 0, 74, 30);

        // long receiver hold-off while segments keep coming
        write_step(17'd6554);
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_req = ~hold_req;
        repeat (20) segs_pending.push_back(rand_seg());
        wait_drained();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
